### design/fourier_form_factor_trapezoid_core_macros.svh
// Assertion macros for the form factor core.
// Used by the top level only; needs a clk and rst_n in scope.
`ifndef FOURIER_FORM_FACTOR_TRAPEZOID_CORE_MACROS_SVH
`define FOURIER_FORM_FACTOR_TRAPEZOID_CORE_MACROS_SVH

// same-cycle implication
`define FFF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/fff_pkg.sv
// Shared types, widths and constants of the form factor core.
// No dependencies.
package fff_pkg;

  localparam int COMPONENTS_DEF   = 4;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ACC_WIDTH_DEF    = 48;

  localparam int NUM_WEIGHTS = 4;
  localparam int DATA_W      = 16;
  localparam int SOLV_W      = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int MRG_W       = 36;   // lane sum minus solvent
  localparam int CON_W       = 28;   // contrast, Q.8
  localparam int ANG_W       = 43;   // angle, Q.30 radians
  localparam int T_W         = 34;   // CORDIC datapath
  localparam int CUR_W       = 40;   // integrand, Q.8
  localparam int AREA_W      = 49;   // trapezoid area, Q.8
  localparam int MAG_W       = 40;
  localparam int RED_STEPS   = 9;    // angle reduction steps, quotient < 512
  localparam int MAX_STEPS   = 24;

  localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
  localparam logic [32:0] PI_Q30      = 33'd3373259426;
  localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
  localparam logic [31:0] GAIN_Q30    = 32'd652032874;
  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_Q      = 3'd0,
    REG_SOLV   = 3'd1,
    REG_SYM    = 3'd2,
    REG_W0     = 3'd3,
    REG_W1     = 3'd4,
    REG_W2     = 3'd5,
    REG_W3     = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_GO, ST_TRIG, ST_AREA, ST_ACC, ST_SQ_GO, ST_ROOT, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    CP_IDLE, CP_REDUCE, CP_FOLD, CP_ROT, CP_DONE
  } cor_phase_t;

  typedef enum logic [2:0] {
    SP_IDLE, SP_SQUARE, SP_ROOT, SP_DONE
  } sq_phase_t;

  typedef struct packed {
    logic signed [T_W-1:0] cos_v;
    logic signed [T_W-1:0] sin_v;
  } trig_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             sat;
  } mag_res_t;

  function automatic logic [30:0] atan_q30(input logic [4:0] i);
    logic [30:0] v;
    unique case (i)
      5'd0:  v = 31'd843314857;
      5'd1:  v = 31'd497837829;
      5'd2:  v = 31'd263043837;
      5'd3:  v = 31'd133525159;
      5'd4:  v = 31'd67021687;
      5'd5:  v = 31'd33543516;
      5'd6:  v = 31'd16775851;
      5'd7:  v = 31'd8388437;
      5'd8:  v = 31'd4194283;
      5'd9:  v = 31'd2097149;
      5'd10: v = 31'd1048576;
      5'd11: v = 31'd524288;
      5'd12: v = 31'd262144;
      5'd13: v = 31'd131072;
      5'd14: v = 31'd65536;
      5'd15: v = 31'd32768;
      5'd16: v = 31'd16384;
      5'd17: v = 31'd8192;
      5'd18: v = 31'd4096;
      5'd19: v = 31'd2048;
      5'd20: v = 31'd1024;
      5'd21: v = 31'd512;
      5'd22: v = 31'd256;
      5'd23: v = 31'd128;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

### design/fourier_form_factor_trapezoid_core.sv
// Fourier form factor magnitude for one q, trapezoid rule: top level.
// Depends on fff_pkg, fff_lanes, fff_cordic, fff_sqrt and the macros header.
//
// Usage:
//  - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets q, solvent
//    density, symmetrized mode and the four weights; always ready, and
//    meant to be written between profiles.
//  - in channel carries one density sample per item; samples of a profile
//    arrive in position order and in_last_sample closes the profile.
//  - out channel gives one item per profile: magnitude and the overflow flag.
// Flow:
//  - one sample at a time: a new sample is taken only after the current one has
//    passed the 9-step angle reduction, the CORDIC rotation loop and accumulation.
//  - the last sample also runs the magnitude unit (6 partial products, then
//    40 root digits) before its result is offered.
// Reset (rst_n low, synchronous) clears config registers, accumulators and
// the output valid flag; the next sample starts a new profile.
// A stalled receiver holds the result in the output register; a following
// profile proceeds and only its final result waits for the register.
`include "fourier_form_factor_trapezoid_core_macros.svh"

module fourier_form_factor_trapezoid_core import fff_pkg::*; #(
  parameter int COMPONENTS   = COMPONENTS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int ACC_WIDTH    = ACC_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_x_pos,
  input  logic signed [DATA_W-1:0] in_density_0,
  input  logic signed [DATA_W-1:0] in_density_1,
  input  logic signed [DATA_W-1:0] in_density_2,
  input  logic signed [DATA_W-1:0] in_density_3,
  input  logic                     in_last_sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [MAG_W-1:0]         out_magnitude,
  output logic                     out_overflow
);

  localparam int LANES = (COMPONENTS > NUM_WEIGHTS) ? NUM_WEIGHTS : COMPONENTS;
  localparam int SUM_W = (ACC_WIDTH > AREA_W) ? ACC_WIDTH + 1 : AREA_W + 1;
  localparam logic signed [SUM_W-1:0] ACC_HI = SUM_W'({(ACC_WIDTH-1){1'b1}});
  localparam logic signed [SUM_W-1:0] ACC_LO = -ACC_HI - SUM_W'(1);

  // configuration registers
  logic [DATA_W-1:0]        q_r;
  logic signed [SOLV_W-1:0] solv_r;
  logic                     sym_r;
  logic signed [DATA_W-1:0] w_r [NUM_WEIGHTS];

  // run state
  state_t state_r, state_nxt;
  logic signed [ACC_WIDTH-1:0] acc_re_r, acc_im_r;
  logic signed [CUR_W-1:0]     prev_re_r, prev_im_r, cur_re_r, cur_im_r;
  logic signed [DATA_W-1:0]    prev_x_r, x_r;
  logic                        first_r, sat_r, last_r;
  logic signed [ANG_W-1:0]     ang_r;
  logic signed [AREA_W-1:0]    area_re_r, area_im_r;
  logic [MAG_W-1:0]            hold_mag_r;
  logic                        hold_ovf_r;
  logic                        out_valid_r, out_ovf_r;
  logic [MAG_W-1:0]            out_mag_r;

  logic accept, cor_start, sq_start, cor_done, sq_done, out_free;
  trig_t    trig;
  mag_res_t mres;
  logic signed [CON_W-1:0]  contrast;
  logic signed [DATA_W-1:0] all_d [NUM_WEIGHTS];
  logic signed [DATA_W-1:0] lane_w [LANES];
  logic signed [DATA_W-1:0] lane_d [LANES];
  logic signed [32:0]       qx_c;
  logic signed [61:0]       pre_c, pim_c;
  logic signed [CUR_W:0]    sre_c, sim_c;
  logic signed [DATA_W:0]   dx_c;
  logic signed [57:0]       are_c, aim_c;
  logic signed [SUM_W-1:0]  nre_c, nim_c;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  // config writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r    <= '0;
      solv_r <= '0;
      sym_r  <= 1'b0;
      for (int k = 0; k < NUM_WEIGHTS; k++) w_r[k] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_Q:    q_r    <= cfg_data[DATA_W-1:0];
        REG_SOLV: solv_r <= cfg_data[SOLV_W-1:0];
        REG_SYM:  sym_r  <= cfg_data[0];
        REG_W0:   w_r[0] <= cfg_data[DATA_W-1:0];
        REG_W1:   w_r[1] <= cfg_data[DATA_W-1:0];
        REG_W2:   w_r[2] <= cfg_data[DATA_W-1:0];
        REG_W3:   w_r[3] <= cfg_data[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  // weighted density lanes
  always_comb begin
    all_d[0] = in_density_0;
    all_d[1] = in_density_1;
    all_d[2] = in_density_2;
    all_d[3] = in_density_3;
    for (int k = 0; k < LANES; k++) begin
      lane_w[k] = w_r[k];
      lane_d[k] = all_d[k];
    end
  end

  fff_lanes #(.LANES(LANES)) u_lanes (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .weights  (lane_w),
    .dens     (lane_d),
    .solvent  (solv_r),
    .contrast (contrast)
  );

  fff_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .ang   (ang_r),
    .res   (trig),
    .done  (cor_done)
  );

  fff_sqrt #(.ACC_WIDTH(ACC_WIDTH)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .re    (acc_re_r),
    .im    (acc_im_r),
    .res   (mres),
    .done  (sq_done)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_GO;
      ST_GO:    state_nxt = ST_TRIG;
      ST_TRIG:  if (cor_done) state_nxt = ST_AREA;
      ST_AREA:  state_nxt = ST_ACC;
      ST_ACC:   state_nxt = last_r ? ST_SQ_GO : ST_IDLE;
      ST_SQ_GO: state_nxt = ST_ROOT;
      ST_ROOT:  if (sq_done) state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    cor_start = 1'b0;
    sq_start  = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ready  = 1'b1;
      ST_GO:    cor_start = 1'b1;
      ST_SQ_GO: sq_start  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath arithmetic
  always_comb begin
    qx_c  = 33'(signed'({1'b0, q_r})) * 33'(in_x_pos);
    pre_c = 62'(contrast) * 62'(trig.cos_v);
    pim_c = 62'(contrast) * 62'(trig.sin_v);
    sre_c = (CUR_W+1)'(cur_re_r) + (CUR_W+1)'(prev_re_r);
    sim_c = (CUR_W+1)'(cur_im_r) + (CUR_W+1)'(prev_im_r);
    dx_c  = (DATA_W+1)'(x_r) - (DATA_W+1)'(prev_x_r);
    are_c = 58'(sre_c) * 58'(dx_c);
    aim_c = 58'(sim_c) * 58'(dx_c);
    nre_c = SUM_W'(acc_re_r) + SUM_W'(area_re_r);
    nim_c = SUM_W'(acc_im_r) + SUM_W'(area_im_r);
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= in_x_pos;
      last_r <= in_last_sample;
      ang_r  <= ANG_W'(qx_c) <<< 10;
    end
    if (state_r == ST_TRIG && cor_done) begin
      // integrand, round half up from Q.38 to Q.8; always within 40 bits
      cur_re_r <= CUR_W'((pre_c + 62'(1 <<< 29)) >>> 30);
      cur_im_r <= sym_r ? '0 : CUR_W'((pim_c + 62'(1 <<< 29)) >>> 30);
    end
    if (state_r == ST_AREA) begin
      area_re_r <= AREA_W'((are_c + 58'(256)) >>> 9);
      area_im_r <= AREA_W'((aim_c + 58'(256)) >>> 9);
    end
    if (state_r == ST_ROOT && sq_done) begin
      hold_mag_r <= mres.mag;
      hold_ovf_r <= sat_r || mres.sat;
    end
  end

  // run state: accumulators, previous sample, saturation flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_re_r  <= '0;
      acc_im_r  <= '0;
      prev_re_r <= '0;
      prev_im_r <= '0;
      prev_x_r  <= '0;
      first_r   <= 1'b1;
      sat_r     <= 1'b0;
    end else if (state_r == ST_ACC) begin
      if (!first_r) begin
        if (nre_c > ACC_HI) begin
          acc_re_r <= ACC_WIDTH'(ACC_HI);
          sat_r    <= 1'b1;
        end else if (nre_c < ACC_LO) begin
          acc_re_r <= ACC_WIDTH'(ACC_LO);
          sat_r    <= 1'b1;
        end else begin
          acc_re_r <= ACC_WIDTH'(nre_c);
        end
        if (nim_c > ACC_HI) begin
          acc_im_r <= ACC_WIDTH'(ACC_HI);
          sat_r    <= 1'b1;
        end else if (nim_c < ACC_LO) begin
          acc_im_r <= ACC_WIDTH'(ACC_LO);
          sat_r    <= 1'b1;
        end else begin
          acc_im_r <= ACC_WIDTH'(nim_c);
        end
      end
      prev_re_r <= cur_re_r;
      prev_im_r <= cur_im_r;
      prev_x_r  <= x_r;
      first_r   <= 1'b0;
    end else if (state_r == ST_ROOT && sq_done) begin
      // result taken: start a fresh profile
      acc_re_r  <= '0;
      acc_im_r  <= '0;
      prev_re_r <= '0;
      prev_im_r <= '0;
      prev_x_r  <= '0;
      first_r   <= 1'b1;
      sat_r     <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_mag_r <= hold_mag_r;
      out_ovf_r <= hold_ovf_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_magnitude = out_mag_r;
  assign out_overflow  = out_ovf_r;

  `FFF_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "item accepted while busy")
  `FFF_ASSERT_NOW(a_cordic_done_state, cor_done, state_r == ST_TRIG, "stray CORDIC done")
  `FFF_ASSERT_NOW(a_sqrt_done_state, sq_done, state_r == ST_ROOT, "stray magnitude done")
  `FFF_ASSERT_NEXT(a_run_cleared, sq_done, first_r && !sat_r && acc_re_r == '0, "run not cleared")

endmodule

### design/fff_lanes.sv
// Per-component weight*density lanes and the merge stage forming contrast.
// Depends on fff_pkg.
module fff_lanes import fff_pkg::*; #(
  parameter int LANES = COMPONENTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  logic signed [DATA_W-1:0] weights [LANES],
  input  logic signed [DATA_W-1:0] dens    [LANES],
  input  logic signed [SOLV_W-1:0] solvent,
  output logic signed [CON_W-1:0]  contrast
);

  logic signed [2*DATA_W-1:0] prod_r [LANES];
  logic                       merge_r;
  logic signed [CON_W-1:0]    contrast_r;
  logic signed [MRG_W-1:0]    sum_c;
  logic signed [MRG_W-1:0]    diff_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      merge_r <= 1'b0;
    end else begin
      merge_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < LANES; k++) begin
        prod_r[k] <= (2*DATA_W)'(weights[k]) * (2*DATA_W)'(dens[k]);
      end
    end
  end

  // merge: sum lanes, remove solvent (Q.16), round half up back to Q.8
  always_comb begin
    sum_c = '0;
    for (int k = 0; k < LANES; k++) begin
      sum_c = sum_c + MRG_W'(prod_r[k]);
    end
    diff_c = sum_c - (MRG_W'(solvent) <<< 8) + MRG_W'(128);
  end

  always_ff @(posedge clk) begin
    if (merge_r) begin
      contrast_r <= CON_W'(diff_c >>> 8);
    end
  end

  assign contrast = contrast_r;

endmodule

### design/fff_cordic.sv
// Angle reduction modulo 2*pi and iterative rotation CORDIC, Q.30.
// Depends on fff_pkg.
module fff_cordic import fff_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [ANG_W-1:0] ang,
  output trig_t                   res,
  output logic                    done
);

  localparam int NSTEP = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  localparam int CNT_W = $clog2(NSTEP);
  localparam int R_W   = 36;
  localparam logic signed [R_W-1:0] TWO_PI_R  = R_W'(TWO_PI_Q30);
  localparam logic signed [R_W-1:0] PI_R      = R_W'(PI_Q30);
  localparam logic signed [R_W-1:0] HALF_PI_R = R_W'(HALF_PI_Q30);

  cor_phase_t phase_r, phase_nxt;
  logic [ANG_W-1:0]      rem_r;
  logic                  neg_r;
  logic [3:0]            k_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  flip_r;
  logic signed [T_W-1:0] x_r, y_r, z_r;

  logic [ANG_W-1:0]      sub_c;
  logic signed [R_W-1:0] r0_c, r1_c, r2_c;
  logic                  flip_c;
  logic signed [T_W-1:0] atan_c;

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      CP_IDLE:   if (start) phase_nxt = CP_REDUCE;
      CP_REDUCE: if (k_r == 4'd0) phase_nxt = CP_FOLD;
      CP_FOLD:   phase_nxt = CP_ROT;
      CP_ROT:    if (cnt_r == CNT_W'(NSTEP - 1)) phase_nxt = CP_DONE;
      CP_DONE:   phase_nxt = CP_IDLE;
      default:   phase_nxt = CP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= CP_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  assign sub_c = ANG_W'(TWO_PI_Q30) << k_r;

  // fold the reduced angle into [-pi/2, pi/2]
  always_comb begin
    if (neg_r && (rem_r != '0)) begin
      r0_c = TWO_PI_R - signed'(R_W'(rem_r));
    end else begin
      r0_c = signed'(R_W'(rem_r));
    end
    r1_c = (r0_c > PI_R) ? r0_c - TWO_PI_R : r0_c;
    flip_c = 1'b0;
    if (r1_c > HALF_PI_R) begin
      r2_c   = r1_c - PI_R;
      flip_c = 1'b1;
    end else if (r1_c < -HALF_PI_R) begin
      r2_c   = r1_c + PI_R;
      flip_c = 1'b1;
    end else begin
      r2_c = r1_c;
    end
  end

  assign atan_c = T_W'(atan_q30(5'(cnt_r)));

  always_ff @(posedge clk) begin
    unique case (phase_r)
      CP_IDLE: begin
        if (start) begin
          rem_r <= ang[ANG_W-1] ? ANG_W'(-ang) : ANG_W'(ang);
          neg_r <= ang[ANG_W-1];
          k_r   <= 4'(RED_STEPS - 1);
        end
      end
      CP_REDUCE: begin
        if (rem_r >= sub_c) rem_r <= rem_r - sub_c;
        k_r <= k_r - 4'd1;
      end
      CP_FOLD: begin
        z_r    <= T_W'(r2_c);
        flip_r <= flip_c;
        x_r    <= T_W'(GAIN_Q30);
        y_r    <= '0;
        cnt_r  <= '0;
      end
      CP_ROT: begin
        if (!z_r[T_W-1]) begin
          x_r <= x_r - (y_r >>> cnt_r);
          y_r <= y_r + (x_r >>> cnt_r);
          z_r <= z_r - atan_c;
        end else begin
          x_r <= x_r + (y_r >>> cnt_r);
          y_r <= y_r - (x_r >>> cnt_r);
          z_r <= z_r + atan_c;
        end
        cnt_r <= cnt_r + CNT_W'(1);
      end
      CP_DONE: ;
      default: ;
    endcase
  end

  assign res.cos_v = flip_r ? -x_r : x_r;
  assign res.sin_v = flip_r ? -y_r : y_r;
  assign done      = (phase_r == CP_DONE);

endmodule

### design/fff_sqrt.sv
// Magnitude unit: squares by 20x20 partial products, then digit-by-digit root.
// Depends on fff_pkg.
module fff_sqrt import fff_pkg::*; #(
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [ACC_WIDTH-1:0] re,
  input  logic signed [ACC_WIDTH-1:0] im,
  output mag_res_t                    res,
  output logic                        done
);

  localparam int EXT_W  = (ACC_WIDTH > MAG_W) ? ACC_WIDTH + 1 : MAG_W + 1;
  localparam int HALF_W = MAG_W / 2;
  localparam int SQ_W   = 2 * MAG_W + 1;
  localparam int IT_W   = $clog2(MAG_W);

  sq_phase_t phase_r, phase_nxt;
  logic [MAG_W-1:0]  opr_r, opi_r;
  logic [SQ_W-1:0]   rad_r;
  logic [MAG_W-1:0]  root_r, rem_r;
  logic [2:0]        part_r;
  logic [IT_W-1:0]   it_r;
  logic              sat_r;

  logic [EXT_W-1:0]    ur_c, ui_c;
  logic                big_c;
  logic [MAG_W-1:0]    op_c;
  logic [HALF_W-1:0]   a_c, b_c;
  logic [2*HALF_W-1:0] pp_c;
  logic [SQ_W-1:0]     term_c;
  logic [MAG_W+1:0]    nrem_c, trial_c;

  always_comb begin
    ur_c  = re[ACC_WIDTH-1] ? EXT_W'(-EXT_W'(re)) : EXT_W'(re);
    ui_c  = im[ACC_WIDTH-1] ? EXT_W'(-EXT_W'(im)) : EXT_W'(im);
    big_c = (ur_c > EXT_W'(MAG_MAX)) || (ui_c > EXT_W'(MAG_MAX));
  end

  // square phase: parts 0..2 for re, 3..5 for im
  always_comb begin
    op_c = (part_r < 3'd3) ? opr_r : opi_r;
    unique case (part_r)
      3'd0, 3'd3: begin
        a_c = op_c[HALF_W-1:0];
        b_c = op_c[HALF_W-1:0];
      end
      3'd1, 3'd4: begin
        a_c = op_c[HALF_W-1:0];
        b_c = op_c[MAG_W-1:HALF_W];
      end
      default: begin
        a_c = op_c[MAG_W-1:HALF_W];
        b_c = op_c[MAG_W-1:HALF_W];
      end
    endcase
    pp_c = (2*HALF_W)'(a_c) * (2*HALF_W)'(b_c);
    unique case (part_r)
      3'd0, 3'd3: term_c = SQ_W'(pp_c);
      3'd1, 3'd4: term_c = SQ_W'(pp_c) << (HALF_W + 1);
      default:    term_c = SQ_W'(pp_c) << MAG_W;
    endcase
  end

  assign nrem_c  = {rem_r, rad_r[2*MAG_W-1 -: 2]};
  assign trial_c = {root_r, 2'b01};

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      SP_IDLE:   if (start) phase_nxt = big_c ? SP_DONE : SP_SQUARE;
      SP_SQUARE: if (part_r == 3'd5) phase_nxt = SP_ROOT;
      SP_ROOT:   if (rad_r[SQ_W-1] || it_r == IT_W'(MAG_W - 1)) phase_nxt = SP_DONE;
      SP_DONE:   phase_nxt = SP_IDLE;
      default:   phase_nxt = SP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= SP_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (phase_r)
      SP_IDLE: begin
        if (start) begin
          opr_r  <= MAG_W'(ur_c);
          opi_r  <= MAG_W'(ui_c);
          sat_r  <= big_c;
          root_r <= big_c ? MAG_MAX : '0;
          rem_r  <= '0;
          rad_r  <= '0;
          part_r <= '0;
          it_r   <= '0;
        end
      end
      SP_SQUARE: begin
        rad_r  <= rad_r + term_c;
        part_r <= part_r + 3'd1;
      end
      SP_ROOT: begin
        if (rad_r[SQ_W-1]) begin
          // sum of squares at or above 2^80
          sat_r  <= 1'b1;
          root_r <= MAG_MAX;
        end else begin
          if (nrem_c >= trial_c) begin
            rem_r  <= MAG_W'(nrem_c - trial_c);
            root_r <= {root_r[MAG_W-2:0], 1'b1};
          end else begin
            rem_r  <= MAG_W'(nrem_c);
            root_r <= {root_r[MAG_W-2:0], 1'b0};
          end
          // top bit stays clear so only the full sum can flag overflow
          rad_r <= {1'b0, rad_r[SQ_W-4:0], 2'b00};
          it_r  <= it_r + IT_W'(1);
        end
      end
      SP_DONE: ;
      default: ;
    endcase
  end

  assign res.mag = root_r;
  assign res.sat = sat_r;
  assign done    = (phase_r == SP_DONE);

endmodule
